// File: design/stma_pkg.sv
// Package for the sparse triplet matrix adder.
// Holds the transaction payload types, command, result-kind and register codes.
// Depends on nothing; every design file refers to it by scoped names.
package stma_pkg;

    // Default and largest store shape.
    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    // Width of a row-major cell index for the largest store.
    localparam int CELL_IDX_W = 6;

    localparam int DIM_W   = 4;
    localparam int POS_W   = 3;
    localparam int VALUE_W = 32;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_ROWS_A = 2'd0;
    localparam logic [1:0] CFG_COLS_A = 2'd1;
    localparam logic [1:0] CFG_ROWS_B = 2'd2;
    localparam logic [1:0] CFG_COLS_B = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Input commands.
    localparam logic CMD_ACCUM  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        KIND_CELL     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_MISMATCH = 2'd2
    } t_kind;

    typedef struct packed {
        logic                      cmd;
        logic [POS_W-1:0]          entry_row;
        logic [POS_W-1:0]          entry_col;
        logic signed [VALUE_W-1:0] entry_value;
    } t_in_item;

    typedef struct packed {
        t_kind                     kind;
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last;
    } t_out_item;

endpackage

// File: design/sparse_triplet_matrix_add.sv
// Sparse triplet matrix adder. Accumulate transactions (cmd 0) add a signed
// 32-bit value into a dense store of MAX_ROWS x MAX_COLS cells; triplets of
// both matrices land in the same store and sums wrap at 32 bits, while a
// triplet with a row or column beyond the store is dropped. Accumulate
// transactions produce no result and are taken one per clock while idle: each
// is a read of the store RAM, an add in the following cycle and a write back,
// with the previous write forwarded when two triplets hit the same cell in a
// row. A finish transaction (cmd 1) compares the configured shapes. On a
// mismatch it returns one result of kind mismatch. Otherwise it scans the cells
// inside the configured shape in row-major order and returns every nonzero cell,
// or one empty result if there is none; the last result of the run carries
// last = 1. The scan visits each cell in a RAM read state, then an evaluation
// state, and returns the final result from a flush state; it waits whenever
// the output register is still held by a stall. During the finish run the input
// channel is stalled. The store is then cleared at once through its per-entry
// written flags, so no clearing pass is needed after reset or finish.
// Configuration registers may be written only while the block is idle.
module sparse_triplet_matrix_add #(
    parameter int MAX_ROWS = stma_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = stma_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input transaction channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  stma_pkg::t_in_item             i_in_data,
    // Result transaction channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output stma_pkg::t_out_item            o_out_data,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [stma_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    // Row-major cell address of a row and column inside the store.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [stma_pkg::POS_W-1:0] row,
        input logic [stma_pkg::POS_W-1:0] col
    );
        logic [stma_pkg::CELL_IDX_W-1:0] idx;
        idx = stma_pkg::CELL_IDX_W'(row) * stma_pkg::CELL_IDX_W'(MAX_COLS)
            + stma_pkg::CELL_IDX_W'(col);
        return idx[ADDR_W-1:0];
    endfunction

    // Configuration registers.
    logic [stma_pkg::DIM_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;

    t_state r_state, n_state;

    // Accumulate pipeline: stage one holds the triplet whose cell is being read.
    logic                              r_s1_valid;
    logic [ADDR_W-1:0]                 r_s1_addr;
    logic [stma_pkg::VALUE_W-1:0]      r_s1_value;
    // Write that was made in the previous cycle, for forwarding.
    logic                              r_wb_valid;
    logic [ADDR_W-1:0]                 r_wb_addr;
    logic [stma_pkg::VALUE_W-1:0]      r_wb_data;

    // Scan position and the nonzero cell held back until its successor is known.
    logic [stma_pkg::POS_W-1:0]        r_row, n_row;
    logic [stma_pkg::POS_W-1:0]        r_col, n_col;
    logic                              r_mismatch, n_mismatch;
    logic                              r_have_pend, n_have_pend;
    logic [stma_pkg::POS_W-1:0]        r_pend_row, n_pend_row;
    logic [stma_pkg::POS_W-1:0]        r_pend_col, n_pend_col;
    logic [stma_pkg::VALUE_W-1:0]      r_pend_value, n_pend_value;

    // Output register.
    logic                              r_out_valid, n_out_valid;
    stma_pkg::t_out_item               r_out, n_out;

    logic                              in_accept;
    logic                              in_range;
    logic                              acc_start;
    logic                              out_free;
    logic [stma_pkg::DIM_W-1:0]        num_rows, num_cols;
    logic                              shape_diff;
    logic                              shape_empty;
    logic                              scan_end;
    logic [stma_pkg::VALUE_W-1:0]      rd_data;
    logic [stma_pkg::VALUE_W-1:0]      acc_base;
    logic [stma_pkg::VALUE_W-1:0]      acc_sum;
    logic                              st_rd_en;
    logic [ADDR_W-1:0]                 st_rd_addr;
    logic                              st_clear;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_in_data.entry_row} < stma_pkg::DIM_W'(MAX_ROWS))
                     && ({1'b0, i_in_data.entry_col} < stma_pkg::DIM_W'(MAX_COLS));
    assign acc_start  = in_accept && (i_in_data.cmd == stma_pkg::CMD_ACCUM) && in_range;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Scan limits: a dimension above the store size is cut to the store size.
    assign num_rows    = (r_rows_a > stma_pkg::DIM_W'(MAX_ROWS))
                       ? stma_pkg::DIM_W'(MAX_ROWS) : r_rows_a;
    assign num_cols    = (r_cols_a > stma_pkg::DIM_W'(MAX_COLS))
                       ? stma_pkg::DIM_W'(MAX_COLS) : r_cols_a;
    assign shape_diff  = (r_rows_a != r_rows_b) || (r_cols_a != r_cols_b);
    assign shape_empty = (num_rows == '0) || (num_cols == '0);
    assign scan_end    = (({1'b0, r_col} + 4'd1) == num_cols)
                      && (({1'b0, r_row} + 4'd1) == num_rows);

    // The RAM read port serves the accumulate path while idle and the scan otherwise.
    assign st_rd_en   = acc_start || (r_state == S_READ);
    assign st_rd_addr = (r_state == S_READ) ? cell_addr(r_row, r_col)
                                            : cell_addr(i_in_data.entry_row,
                                                        i_in_data.entry_col);

    stma_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (acc_sum),
        .i_clear   (st_clear),
        .o_rd_data (rd_data)
    );

    // The RAM read was issued at the same edge as the previous write, so a hit
    // on that write takes the forwarded sum instead of the stale RAM word.
    assign acc_base = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : rd_data;
    assign acc_sum  = acc_base + r_s1_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= stma_pkg::DIM_RESET;
            r_cols_a <= stma_pkg::DIM_RESET;
            r_rows_b <= stma_pkg::DIM_RESET;
            r_cols_b <= stma_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stma_pkg::CFG_ROWS_A: r_rows_a <= i_cfg_data;
                stma_pkg::CFG_COLS_A: r_cols_a <= i_cfg_data;
                stma_pkg::CFG_ROWS_B: r_rows_b <= i_cfg_data;
                stma_pkg::CFG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Scan and result control.
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_mismatch   = r_mismatch;
        n_have_pend  = r_have_pend;
        n_pend_row   = r_pend_row;
        n_pend_col   = r_pend_col;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        st_clear     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.cmd == stma_pkg::CMD_FINISH)) begin
                    n_mismatch = shape_diff;
                    n_row      = '0;
                    n_col      = '0;
                    if (shape_diff || shape_empty) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // A second nonzero cell pushes the held one out, which needs room.
                if (!((rd_data != '0) && r_have_pend && !out_free)) begin
                    if (rd_data != '0) begin
                        if (r_have_pend) begin
                            n_out_valid       = 1'b1;
                            n_out.kind        = stma_pkg::KIND_CELL;
                            n_out.out_row     = r_pend_row;
                            n_out.out_col     = r_pend_col;
                            n_out.out_value   = r_pend_value;
                            n_out.last        = 1'b0;
                        end
                        n_have_pend  = 1'b1;
                        n_pend_row   = r_row;
                        n_pend_col   = r_col;
                        n_pend_value = rd_data;
                    end
                    if (scan_end) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_READ;
                        if (({1'b0, r_col} + 4'd1) == num_cols) begin
                            n_col = '0;
                            n_row = r_row + 3'd1;
                        end else begin
                            n_col = r_col + 3'd1;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.last      = 1'b1;
                    n_out.out_row   = '0;
                    n_out.out_col   = '0;
                    n_out.out_value = '0;
                    if (r_mismatch) begin
                        n_out.kind = stma_pkg::KIND_MISMATCH;
                    end else if (r_have_pend) begin
                        n_out.kind      = stma_pkg::KIND_CELL;
                        n_out.out_row   = r_pend_row;
                        n_out.out_col   = r_pend_col;
                        n_out.out_value = r_pend_value;
                    end else begin
                        n_out.kind = stma_pkg::KIND_EMPTY;
                    end
                    n_have_pend = 1'b0;
                    st_clear    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_have_pend <= 1'b0;
            r_mismatch  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state     <= n_state;
            r_s1_valid  <= acc_start;
            r_wb_valid  <= r_s1_valid;
            r_have_pend <= n_have_pend;
            r_mismatch  <= n_mismatch;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_col       <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr    <= cell_addr(i_in_data.entry_row, i_in_data.entry_col);
        r_s1_value   <= i_in_data.entry_value;
        r_wb_addr    <= r_s1_addr;
        r_wb_data    <= acc_sum;
        r_pend_row   <= n_pend_row;
        r_pend_col   <= n_pend_col;
        r_pend_value <= n_pend_value;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: design/stma_store.sv
// Cell store of the sparse triplet matrix adder: one synchronous RAM of sums
// with a registered read, plus per-entry written flags.
// Depends on stma_pkg for the value width and the default depth.
module stma_store #(
    parameter int DEPTH  = stma_pkg::MAX_ROWS_DEF * stma_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [ADDR_W-1:0]                 i_rd_addr,
    input  logic                              i_wr_en,
    input  logic [ADDR_W-1:0]                 i_wr_addr,
    input  logic [stma_pkg::VALUE_W-1:0]      i_wr_data,
    input  logic                              i_clear,
    output logic [stma_pkg::VALUE_W-1:0]      o_rd_data
);

    logic [stma_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_written;
    logic [stma_pkg::VALUE_W-1:0] r_rd_data;
    logic                         r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry that was never written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_clear) begin
                r_written <= '0;
            end else if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

// File: sim/tb_sparse_triplet_matrix_add.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sparse triplet matrix adder.
// Drives triplet and finish transactions, predicts every result in place and
// compares field by field. Depends on stma_pkg and sparse_triplet_matrix_add.
module tb_sparse_triplet_matrix_add;

    // Cycles to let the accumulate pipeline settle before a register write.
    localparam int SETTLE_CYCLES = 10;
    // Cycles to watch for stray results once nothing is expected.
    localparam int TAIL_CYCLES   = 40;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES   = 300;
    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT      = 11;
    // Least number of input transactions sent over the whole run, directed part included.
    localparam int TOTAL_ITEMS   = 430;
    localparam time RUN_LIMIT    = 4ms;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    stma_pkg::t_in_item             i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    stma_pkg::t_out_item            o_out_data;
    logic                           i_cfg_we;
    logic [1:0]                     i_cfg_index;
    logic [stma_pkg::DIM_W-1:0]     i_cfg_data;

    sparse_triplet_matrix_add i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Mirror of the block: the dense cell store and the four shape
    // registers, updated as transactions and writes are accepted.
    // ------------------------------------------------------------------
    logic [stma_pkg::VALUE_W-1:0] cell_mirror [stma_pkg::MAX_ROWS_DEF*stma_pkg::MAX_COLS_DEF];
    logic [stma_pkg::DIM_W-1:0]   shape_rows_a, shape_cols_a, shape_rows_b, shape_cols_b;

    // Results still owed by the block, oldest first.
    stma_pkg::t_out_item scan_results_due [$];

    int  fault_count    = 0;
    int  items_taken    = 0;
    int  finish_runs    = 0;
    int  shape_writes   = 0;
    int  results_seen   = 0;
    int  widest_run     = 0;
    // Set by the sender to suppress all idling on both sides for a while.
    bit  calm           = 0;
    // Set by the sender to ask the receiver for one long hold-off.
    bit  hold_pending   = 0;

    // One row of the directed table: either a shape change or a transaction.
    // Finish rows whose answer is obvious carry the expected kind typed in.
    typedef struct {
        bit                         is_shape;
        logic [stma_pkg::DIM_W-1:0] ra, ca, rb, cb;
        stma_pkg::t_in_item         item;
        bit                         typed;
        stma_pkg::t_kind            typed_kind;
    } t_dir_row;

    t_dir_row directed_rows [$];

    // ------------------------------------------------------------------
    // Predictor. An accumulate adds the value into its cell with 32-bit
    // wrap. A finish compares the raw shape registers; on a mismatch it
    // owes one mismatch result. Otherwise it walks the configured shape
    // (each dimension capped at the store size) in row-major order and owes
    // every nonzero cell, or one empty result, with last on the final one.
    // Every finish clears the store. With keep cleared, the state advances
    // but nothing is queued (the caller queues a typed answer instead).
    // ------------------------------------------------------------------
    task automatic sum_and_scan(input stma_pkg::t_in_item it, input bit keep);
        stma_pkg::t_out_item run [$];
        stma_pkg::t_out_item res;
        int unsigned         nr, nc;
        if (it.cmd == stma_pkg::CMD_ACCUM) begin
            cell_mirror[{it.entry_row, it.entry_col}] += it.entry_value;
        end else begin
            res = '0;
            if (shape_rows_a != shape_rows_b || shape_cols_a != shape_cols_b) begin
                res.kind = stma_pkg::KIND_MISMATCH;
                res.last = 1'b1;
                run.push_back(res);
            end else begin
                nr = (shape_rows_a > stma_pkg::MAX_ROWS_DEF)
                   ? stma_pkg::MAX_ROWS_DEF : shape_rows_a;
                nc = (shape_cols_a > stma_pkg::MAX_COLS_DEF)
                   ? stma_pkg::MAX_COLS_DEF : shape_cols_a;
                for (int r = 0; r < nr; r++) begin
                    for (int c = 0; c < nc; c++) begin
                        if (cell_mirror[r*stma_pkg::MAX_COLS_DEF + c] != '0) begin
                            res           = '0;
                            res.kind      = stma_pkg::KIND_CELL;
                            res.out_row   = r[stma_pkg::POS_W-1:0];
                            res.out_col   = c[stma_pkg::POS_W-1:0];
                            res.out_value = cell_mirror[r*stma_pkg::MAX_COLS_DEF + c];
                            run.push_back(res);
                        end
                    end
                end
                if (run.size() == 0) begin
                    res.kind = stma_pkg::KIND_EMPTY;
                    res.last = 1'b1;
                    run.push_back(res);
                end else begin
                    run[run.size()-1].last = 1'b1;
                end
            end
            foreach (cell_mirror[i]) cell_mirror[i] = '0;
            if (run.size() > widest_run) widest_run = run.size();
            if (keep) begin
                foreach (run[i]) scan_results_due.push_back(run[i]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the receiver side.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random, except in the calm stretch. Once the
    // sender asks for it, it holds the output off for a long, counted run
    // of cycles so the block backs up into its input channel.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 0;
                i_out_stall <= 1'b1;
                for (int k = 1; k < HOLD_CYCLES; k++) @(negedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", fname, want_v, got_v);
            fault_count++;
        end
    endtask

    // Every accepted result is matched against the oldest one owed.
    always @(posedge i_clk) begin
        stma_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (scan_results_due.size() == 0) begin
                $error("result with nothing owed: kind %0d row %0d col %0d value %0h",
                       o_out_data.kind, o_out_data.out_row, o_out_data.out_col,
                       o_out_data.out_value);
                fault_count++;
            end else begin
                want = scan_results_due.pop_front();
                check_field("kind",      want.kind,      o_out_data.kind);
                check_field("out_row",   want.out_row,   o_out_data.out_row);
                check_field("out_col",   want.out_col,   o_out_data.out_col);
                check_field("out_value", want.out_value, o_out_data.out_value);
                check_field("last",      want.last,      o_out_data.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one transaction, with random idle cycles ahead of it, and
    // holds it until the block takes it. Valid stays high after acceptance;
    // the next offer or a pause decides its value at the next falling edge.
    task automatic offer(input stma_pkg::t_in_item it, input bit typed,
                         input stma_pkg::t_kind typed_kind);
        stma_pkg::t_out_item res;
        @(negedge i_clk);
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_taken++;
        if (it.cmd == stma_pkg::CMD_FINISH) finish_runs++;
        sum_and_scan(it, !typed);
        if (typed) begin
            res      = '0;
            res.kind = typed_kind;
            res.last = 1'b1;
            scan_results_due.push_back(res);
        end
    endtask

    // Drops valid and waits until every owed result has arrived, then lets
    // a trailing accumulate drain out of the pipeline.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [stma_pkg::DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            stma_pkg::CFG_ROWS_A: shape_rows_a = val;
            stma_pkg::CFG_COLS_A: shape_cols_a = val;
            stma_pkg::CFG_ROWS_B: shape_rows_b = val;
            stma_pkg::CFG_COLS_B: shape_cols_b = val;
            default: ;
        endcase
    endtask

    // Shape changes only happen with the block idle.
    task automatic set_shape(input logic [stma_pkg::DIM_W-1:0] ra, ca, rb, cb);
        wait_idle();
        write_reg(stma_pkg::CFG_ROWS_A, ra);
        write_reg(stma_pkg::CFG_COLS_A, ca);
        write_reg(stma_pkg::CFG_ROWS_B, rb);
        write_reg(stma_pkg::CFG_COLS_B, cb);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shape_writes++;
    endtask

    function automatic stma_pkg::t_in_item make_item(input logic cmd, input int r,
                                                     input int c, input logic [31:0] v);
        stma_pkg::t_in_item it;
        it.cmd         = cmd;
        it.entry_row   = r[stma_pkg::POS_W-1:0];
        it.entry_col   = c[stma_pkg::POS_W-1:0];
        it.entry_value = v;
        return it;
    endfunction

    function automatic t_dir_row row_acc(input int r, input int c, input logic [31:0] v);
        t_dir_row d;
        d          = '{typed_kind: stma_pkg::KIND_CELL, default: '0};
        d.item     = make_item(stma_pkg::CMD_ACCUM, r, c, v);
        return d;
    endfunction

    function automatic t_dir_row row_fin(input bit typed, input stma_pkg::t_kind k);
        t_dir_row d;
        d            = '{typed_kind: stma_pkg::KIND_CELL, default: '0};
        d.item       = make_item(stma_pkg::CMD_FINISH, 0, 0, '0);
        d.typed      = typed;
        d.typed_kind = k;
        return d;
    endfunction

    function automatic t_dir_row row_shape(input logic [stma_pkg::DIM_W-1:0] ra, ca, rb, cb);
        t_dir_row d;
        d          = '{typed_kind: stma_pkg::KIND_CELL, default: '0};
        d.is_shape = 1'b1;
        d.ra       = ra;
        d.ca       = ca;
        d.rb       = rb;
        d.cb       = cb;
        return d;
    endfunction

    // Random value with the 32-bit extremes and zero well represented.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        t_dir_row                   d;
        stma_pkg::t_in_item         it;
        stma_pkg::t_in_item         prev;
        int                         phase_no;
        int                         n_acc;
        int                         eff_rows, eff_cols;
        int                         r, c;
        bit                         dense, keep_shape;
        logic [stma_pkg::DIM_W-1:0] ra, ca, rb, cb;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = stma_pkg::CFG_ROWS_A;
        i_cfg_data  = '0;
        foreach (cell_mirror[i]) cell_mirror[i] = '0;
        shape_rows_a = stma_pkg::DIM_RESET;
        shape_cols_a = stma_pkg::DIM_RESET;
        shape_rows_b = stma_pkg::DIM_RESET;
        shape_cols_b = stma_pkg::DIM_RESET;
        prev         = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A finish straight after reset sees an empty store.
        directed_rows.push_back(row_fin(1, stma_pkg::KIND_EMPTY));
        // Positive and negative wrap, a cell that cancels to zero, far corners.
        directed_rows.push_back(row_acc(0, 0, 32'h7FFF_FFFF));
        directed_rows.push_back(row_acc(0, 0, 32'h0000_0001));
        directed_rows.push_back(row_acc(7, 7, 32'h8000_0000));
        directed_rows.push_back(row_acc(7, 7, 32'hFFFF_FFFF));
        directed_rows.push_back(row_acc(3, 4, 32'd5));
        directed_rows.push_back(row_acc(3, 4, -32'sd5));
        directed_rows.push_back(row_acc(0, 7, 32'd1));
        directed_rows.push_back(row_fin(0, stma_pkg::KIND_CELL));
        // Smallest shape: a triplet outside it stays hidden.
        directed_rows.push_back(row_shape(1, 1, 1, 1));
        directed_rows.push_back(row_acc(0, 0, 32'd3));
        directed_rows.push_back(row_acc(1, 0, 32'd4));
        directed_rows.push_back(row_fin(0, stma_pkg::KIND_CELL));
        // Row counts differ, then column counts differ.
        directed_rows.push_back(row_shape(4, 8, 8, 8));
        directed_rows.push_back(row_acc(1, 1, 32'd9));
        directed_rows.push_back(row_fin(1, stma_pkg::KIND_MISMATCH));
        directed_rows.push_back(row_shape(8, 3, 8, 5));
        directed_rows.push_back(row_fin(1, stma_pkg::KIND_MISMATCH));
        // Zero dimensions scan nothing.
        directed_rows.push_back(row_shape(0, 0, 0, 0));
        directed_rows.push_back(row_acc(0, 0, 32'd1));
        directed_rows.push_back(row_fin(1, stma_pkg::KIND_EMPTY));
        // Largest register values are cut to the store size.
        directed_rows.push_back(row_shape(15, 15, 15, 15));
        directed_rows.push_back(row_acc(7, 0, 32'd2));
        directed_rows.push_back(row_acc(7, 7, 32'hFFFF_FFFF));
        directed_rows.push_back(row_fin(0, stma_pkg::KIND_CELL));
        // The store was cleared by the last finish.
        directed_rows.push_back(row_shape(8, 8, 8, 8));
        directed_rows.push_back(row_fin(1, stma_pkg::KIND_EMPTY));

        foreach (directed_rows[i]) begin
            d = directed_rows[i];
            if (d.is_shape) set_shape(d.ra, d.ca, d.rb, d.cb);
            else            offer(d.item, d.typed, d.typed_kind);
        end

        // Random part: phases of triplets closed by a finish. Most phases
        // use a new shape so the scan runs on varied sizes. Two phases fill
        // every cell for the longest scan, and the phase after each of them
        // keeps the shape and runs straight on into the busy scan. The first
        // dense phase also starts the long receiver hold-off.
        phase_no   = 0;
        keep_shape = 0;
        while (items_taken < TOTAL_ITEMS) begin
            phase_no++;
            dense = (phase_no == 5) || (phase_no == 32);
            calm  = (phase_no >= 15) && (phase_no < 25);
            if (dense) begin
                set_shape(8, 8, 8, 8);
            end else if (!keep_shape) begin
                case ($urandom_range(9))
                    0, 1: begin
                        // Mismatch: raw values, at least one pair differs.
                        ra = stma_pkg::DIM_W'($urandom_range(15));
                        ca = stma_pkg::DIM_W'($urandom_range(15));
                        rb = stma_pkg::DIM_W'($urandom_range(15));
                        cb = stma_pkg::DIM_W'($urandom_range(15));
                        if (ra == rb && ca == cb) rb = ra + 4'd1;
                    end
                    2: begin
                        ra = stma_pkg::DIM_W'($urandom_range(15));
                        ca = stma_pkg::DIM_W'($urandom_range(15));
                        rb = ra;
                        cb = ca;
                    end
                    default: begin
                        ra = stma_pkg::DIM_W'($urandom_range(1, 8));
                        ca = stma_pkg::DIM_W'($urandom_range(1, 8));
                        rb = ra;
                        cb = ca;
                    end
                endcase
                set_shape(ra, ca, rb, cb);
            end
            keep_shape = dense;

            eff_rows = (shape_rows_a > stma_pkg::MAX_ROWS_DEF)
                     ? stma_pkg::MAX_ROWS_DEF : shape_rows_a;
            eff_cols = (shape_cols_a > stma_pkg::MAX_COLS_DEF)
                     ? stma_pkg::MAX_COLS_DEF : shape_cols_a;

            if (dense) begin
                if (phase_no == 5) hold_pending = 1;
                for (int k = 0; k < stma_pkg::MAX_ROWS_DEF*stma_pkg::MAX_COLS_DEF; k++) begin
                    it = make_item(stma_pkg::CMD_ACCUM, k / stma_pkg::MAX_COLS_DEF,
                                   k % stma_pkg::MAX_COLS_DEF, $urandom | 32'h1);
                    offer(it, 0, stma_pkg::KIND_CELL);
                end
            end else begin
                n_acc = $urandom_range(0, 12);
                for (int k = 0; k < n_acc; k++) begin
                    if ($urandom_range(99) < 15 && prev.cmd == stma_pkg::CMD_ACCUM) begin
                        // Undo the previous triplet so its cell gets back the value it held before that triplet.
                        it = prev;
                        it.entry_value = -prev.entry_value;
                    end else begin
                        if (eff_rows > 0 && eff_cols > 0 && $urandom_range(3) != 0) begin
                            r = $urandom_range(0, eff_rows - 1);
                            c = $urandom_range(0, eff_cols - 1);
                        end else begin
                            r = $urandom_range(0, 7);
                            c = $urandom_range(0, 7);
                        end
                        it = make_item(stma_pkg::CMD_ACCUM, r, c, pick_value());
                    end
                    offer(it, 0, stma_pkg::KIND_CELL);
                    prev = it;
                end
            end
            // A finish carries random position and value bits; they are unused.
            it = make_item(stma_pkg::CMD_FINISH, $urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom);
            offer(it, 0, stma_pkg::KIND_CELL);
            prev = it;
        end
        calm = 0;

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions in %0d finish runs over %0d shape settings.",
                 items_taken, finish_runs, shape_writes);
        $display("Compared %0d results; the longest finish run returned %0d.",
                 results_seen, widest_run);
        if (fault_count == 0 && scan_results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop in case the block hangs or never delivers a result.
    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
